// ===== sv/its_pkg.sv =====
package its_pkg;

	localparam int TF_W      = 24;
	localparam int LEN_W     = 24;
	localparam int CAV_W     = 40;
	localparam int QIDF_W    = 32;
	localparam int SCORE_W   = 32;
	localparam int CFG_W     = 40;
	localparam int CFG_IDX_W = 1;
	localparam int X_W       = CAV_W + 1;
	localparam int POS_W     = 6;
	localparam int LGI_W     = 6;
	localparam int NORM_W    = 32;
	localparam int MANT_FRAC = 30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C_AVLEN,
		REG_QUERY_IDF
	} cfg_reg_t;

	typedef struct packed {
		logic zero_tf;
		logic zero_len;
	} post_flags_t;

	typedef struct packed {
		post_flags_t       flags;
		logic [TF_W-1:0]   tf;
	} post_tag_t;

	// Fraction bits of log2(1 + idx / 2^lbits) by repeated squaring of a Q2.30 mantissa.
	function automatic logic [63:0] log_frac(int idx, int lbits, int fbits);
		logic [63:0] y;
		logic [63:0] bits;
		logic [63:0] mask;
		mask = (64'd1 << lbits) - 64'd1;
		y = (64'd1 << MANT_FRAC) + ((64'(idx) & mask) << (MANT_FRAC - lbits));
		bits = '0;
		for (int k = 0; k < fbits; k++) begin
			y = (y * y) >> MANT_FRAC;
			bits = bits << 1;
			if (y >= (64'd2 << MANT_FRAC)) begin
				bits = bits | 64'd1;
				y = y >> 1;
			end
		end
		return bits;
	endfunction

endpackage

// ===== sv/its_if.sv =====
interface its_in_if import its_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TF_W-1:0]   term_frequency;
	logic [LEN_W-1:0]  doc_len;

	modport source (output valid, output term_frequency, output doc_len, input ready);
	modport sink (input valid, input term_frequency, input doc_len, output ready);
	modport monitor (input valid, input term_frequency, input doc_len, input ready);
endinterface

interface its_out_if import its_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] score;

	modport source (output valid, output score, input ready);
	modport sink (input valid, input score, output ready);
	modport monitor (input valid, input score, input ready);
endinterface

// ===== sv/its_div.sv =====
module its_div import its_pkg::*; #(
	parameter int Q_W   = 32,
	parameter int DEN_W = 32,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DEN_W-1:0] in_rem,
	input  logic [Q_W-1:0]   in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output logic [Q_W-1:0]   out_quot,
	output logic [TAG_W-1:0] out_tag
);

	// Index 0 is the input; index k holds the result of stage k.
	logic             v_s   [Q_W+1];
	logic [DEN_W-1:0] rem_s [Q_W+1];
	logic [Q_W-1:0]   num_s [Q_W+1];
	logic [DEN_W-1:0] den_s [Q_W+1];
	logic [TAG_W-1:0] tag_s [Q_W+1];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = in_rem;
	assign num_s[0] = in_num;
	assign den_s[0] = in_den;
	assign tag_s[0] = in_tag;

	// Each stage retires one quotient bit, shifted into the low end of the numerator word.
	for (genvar k = 1; k <= Q_W; k++) begin : g_stage
		logic [DEN_W:0]   trial;
		logic             ge;
		logic [DEN_W:0]   diff;

		assign trial = {rem_s[k-1], num_s[k-1][Q_W-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				num_s[k] <= {num_s[k-1][Q_W-2:0], ge};
				den_s[k] <= den_s[k-1];
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	assign out_valid = v_s[Q_W];
	assign out_quot  = num_s[Q_W];
	assign out_tag   = tag_s[Q_W];

endmodule

// ===== sv/its_log.sv =====
module its_log import its_pkg::*; #(
	parameter int FRAC_BITS      = 16,
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic [X_W-1:0]              x,
	input  logic [POS_W-1:0]            pos,
	output logic [FRAC_BITS+LGI_W-1:0]  lg
);

	localparam int ENTRIES = 1 << LOG_TABLE_BITS;

	logic [FRAC_BITS-1:0]          frac_tab [ENTRIES];
	logic [X_W+LOG_TABLE_BITS-1:0] ext;
	logic [LOG_TABLE_BITS-1:0]     idx;
	logic [LGI_W-1:0]              int_part;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_tab
		localparam logic [63:0] ENTRY = log_frac(i, LOG_TABLE_BITS, FRAC_BITS);
		assign frac_tab[i] = ENTRY[FRAC_BITS-1:0];
	end

	// The bits just below the leading one, with zeros filled in below bit 0.
	assign ext      = {x, {LOG_TABLE_BITS{1'b0}}} >> pos;
	assign idx      = ext[LOG_TABLE_BITS-1:0];
	assign int_part = LGI_W'(int'(pos) - FRAC_BITS);
	assign lg       = {int_part, frac_tab[idx]};

endmodule

// ===== sv/inl2_term_score_unit.sv =====
// Channel   Direction  Payload
// in_ch     sink       term_frequency[23:0], doc_len[23:0]
// out_ch    source     score[31:0]
// cfg       write      cfg_we, cfg_index[0:0], cfg_wdata[39:0]
//
// One request enters per cycle unless the output stalls. The pipeline holds the
// 40 stages of the ratio divider, the 32 stages of the score divider and nine other
// register stages. Reset restores both registers to 1.0 and empties the pipeline.
// A stalled output holds the whole pipeline in place; nothing is dropped or repeated.
module inl2_term_score_unit import its_pkg::*; #(
	parameter int FRAC_BITS      = 16,
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	its_in_if.sink               in_ch,
	its_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int LG_W = FRAC_BITS + LGI_W;
	localparam int N_W  = TF_W + LG_W;
	localparam int D_W  = N_W + 1;

	logic [CAV_W-1:0]  c_avlen_q;
	logic [QIDF_W-1:0] qidf_q;
	logic              en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_avlen_q <= CAV_W'(1) << FRAC_BITS;
			qidf_q    <= QIDF_W'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_C_AVLEN:   c_avlen_q <= cfg_wdata[CAV_W-1:0];
				REG_QUERY_IDF: qidf_q    <= cfg_wdata[QIDF_W-1:0];
				default: ;
			endcase
		end
	end

	logic               out_valid_q;
	logic [SCORE_W-1:0] score_q;

	assign en          = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	// Stage 1: capture the posting.
	logic             v_s1;
	post_tag_t        tag_s1;
	logic [LEN_W-1:0] len_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1.tf             <= in_ch.term_frequency;
			tag_s1.flags.zero_tf  <= in_ch.term_frequency == '0;
			tag_s1.flags.zero_len <= in_ch.doc_len == '0;
			len_s1                <= in_ch.doc_len;
		end
	end

	// Ratio c_times_avg_length / doc_len.
	logic             v_d1;
	logic [CAV_W-1:0] ratio_d1;
	post_tag_t        tag_d1;

	its_div #(.Q_W(CAV_W), .DEN_W(LEN_W), .TAG_W($bits(post_tag_t))) u_div_ratio (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_rem('0), .in_num(c_avlen_q), .in_den(len_s1), .in_tag(tag_s1),
		.out_valid(v_d1), .out_quot(ratio_d1), .out_tag(tag_d1)
	);

	// Stage 2: x = 1.0 + ratio.
	logic           v_s2;
	post_tag_t      tag_s2;
	logic [X_W-1:0] x_s2;

	// Stage 3: leading one of x.
	logic             v_s3;
	post_tag_t        tag_s3;
	logic [X_W-1:0]   x_s3;
	logic [POS_W-1:0] pos_s3;
	logic [POS_W-1:0] pos_c;

	always_comb begin
		pos_c = '0;
		for (int i = 0; i < X_W; i++) begin
			if (x_s2[i]) begin
				pos_c = POS_W'(i);
			end
		end
	end

	// Stage 4: log2(x).
	logic            v_s4;
	post_tag_t       tag_s4;
	logic [LG_W-1:0] lg_s4;
	logic [LG_W-1:0] lg_c;

	its_log #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log (
		.x(x_s3), .pos(pos_s3), .lg(lg_c)
	);

	// Stage 5: n = tf * log2(x).
	logic           v_s5;
	post_flags_t    fl_s5;
	logic [N_W-1:0] n_s5;

	// Stage 6: d = n + 1.0 and the shift that brings d under 2^32.
	logic             v_s6;
	post_flags_t      fl_s6;
	logic [N_W-1:0]   n_s6;
	logic [D_W-1:0]   d_s6;
	logic [POS_W-1:0] sh_s6;
	logic [D_W-1:0]   d_c;
	logic [POS_W-1:0] msb_c;

	assign d_c = D_W'(n_s5) + (D_W'(1) << FRAC_BITS);

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < D_W; i++) begin
			if (d_c[i]) begin
				msb_c = POS_W'(i);
			end
		end
	end

	// Stage 7: normalized n and d.
	logic              v_s7;
	post_flags_t       fl_s7;
	logic [NORM_W-1:0] nn_s7;
	logic [NORM_W-1:0] dd_s7;
	logic [N_W-1:0]    n_sh;
	logic [D_W-1:0]    d_sh;

	assign n_sh = n_s6 >> sh_s6;
	assign d_sh = d_s6 >> sh_s6;

	// Stage 8: query_idf_weight * n.
	logic                 v_s8;
	post_flags_t          fl_s8;
	logic [2*NORM_W-1:0]  prod_s8;
	logic [NORM_W-1:0]    dd_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_d1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2  <= tag_d1;
			x_s2    <= X_W'(ratio_d1) + (X_W'(1) << FRAC_BITS);
			tag_s3  <= tag_s2;
			x_s3    <= x_s2;
			pos_s3  <= pos_c;
			tag_s4  <= tag_s3;
			lg_s4   <= lg_c;
			fl_s5   <= tag_s4.flags;
			n_s5    <= N_W'(tag_s4.tf) * N_W'(lg_s4);
			fl_s6   <= fl_s5;
			n_s6    <= n_s5;
			d_s6    <= d_c;
			sh_s6   <= (msb_c > POS_W'(NORM_W - 1)) ? msb_c - POS_W'(NORM_W - 1) : '0;
			fl_s7   <= fl_s6;
			nn_s7   <= n_sh[NORM_W-1:0];
			dd_s7   <= d_sh[NORM_W-1:0];
			fl_s8   <= fl_s7;
			prod_s8 <= (2*NORM_W)'(qidf_q) * (2*NORM_W)'(nn_s7);
			dd_s8   <= dd_s7;
		end
	end

	// Score quotient; n < d keeps it within 32 bits.
	logic               v_d2;
	logic [NORM_W-1:0]  quot_d2;
	post_flags_t        fl_d2;

	its_div #(.Q_W(NORM_W), .DEN_W(NORM_W), .TAG_W($bits(post_flags_t))) u_div_score (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s8), .in_rem(prod_s8[2*NORM_W-1:NORM_W]), .in_num(prod_s8[NORM_W-1:0]),
		.in_den(dd_s8), .in_tag(fl_s8),
		.out_valid(v_d2), .out_quot(quot_d2), .out_tag(fl_d2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (fl_d2.zero_tf) begin
				score_q <= '0;
			end else if (fl_d2.zero_len) begin
				score_q <= qidf_q;
			end else begin
				score_q <= quot_d2;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.score = score_q;

endmodule

// ===== sv/its_chk.sv =====
module its_chk import its_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_ready,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [SCORE_W-1:0]   out_score,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [QIDF_W-1:0] qidf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qidf_q <= QIDF_W'(1) << FRAC_BITS;
		end else if (cfg_we && cfg_reg_t'(cfg_index) == REG_QUERY_IDF) begin
			qidf_q <= cfg_wdata[QIDF_W-1:0];
		end
	end

	// A waiting score freezes the input side.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input ready while the output stalls");

	// The score never exceeds the query weight.
	a_score_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_score <= qidf_q)
		else $error("score above query weight");

	// The pipeline comes out of reset empty.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_score))
		else $error("stalled result changed");

endmodule

bind inl2_term_score_unit its_chk #(.FRAC_BITS(FRAC_BITS)) u_its_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_score(out_ch.score),
	.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
);

// ===== dv/inl2_term_score_unit_test.sv =====
module inl2_term_score_unit_test;
	import its_pkg::*;

	localparam int PIPE_LAT    = 81;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	its_in_if in_ch ();
	its_out_if out_ch ();

	inl2_term_score_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	logic [CAV_W-1:0] c_avlen_q;
	logic [QIDF_W-1:0] query_idf_q;
	logic [15:0] log_frac_tab [256];
	logic [SCORE_W-1:0] score_fifo [$];
	logic idle_on = 1'b1;
	int n_requests = 0;
	int n_scores = 0;
	int n_errors = 0;
	int n_mismatch = 0;
	int n_cfg = 0;
	int cycles = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.term_frequency = '0;
		in_ch.doc_len = '0;
		out_ch.ready = 1'b0;
	end

	// Fraction of log2(1 + i/256) by squaring a Q2.30 mantissa, one bit per step.
	function automatic logic [15:0] build_log_frac(int i);
		logic [63:0] m;
		logic [15:0] f;
		m = (64'd1 << 30) + (64'(i) << 22);
		f = '0;
		for (int k = 0; k < 16; k++) begin
			m = (m * m) >> 30;
			f = f << 1;
			if (m >= (64'd2 << 30)) begin
				f[0] = 1'b1;
				m = m >> 1;
			end
		end
		return f;
	endfunction

	function automatic logic [SCORE_W-1:0] inl2_score(logic [TF_W-1:0] tf,
			logic [LEN_W-1:0] len);
		logic [63:0] x;
		logic [63:0] lg;
		logic [63:0] n;
		logic [63:0] d;
		logic [7:0] li;
		int p;
		if (tf == 0) return '0;
		if (len == 0) return query_idf_q;
		x = 64'd65536 + 64'(c_avlen_q) / 64'(len);
		p = 63;
		while (p > 0 && !x[p]) p--;
		li = 8'(x >> (p - 8));
		lg = (64'(p - 16) << 16) + 64'(log_frac_tab[li]);
		n = 64'(tf) * lg;
		d = n + 64'd65536;
		while (d >= (64'd1 << 32)) begin
			d = d >> 1;
			n = n >> 1;
		end
		return SCORE_W'((64'(query_idf_q) * n) / d);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("inl2_term_score_unit verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= idle_on ? ($urandom_range(99) >= 20) : 1'b1;
	end

	// Sampled mid-cycle; ready only changes at the rising edge.
	always @(negedge clk) begin
		logic [SCORE_W-1:0] want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
			n_scores++;
			if (score_fifo.size() == 0) begin
				n_errors++;
				$display("score 0x%08h with no request outstanding", out_ch.score);
			end else begin
				want = score_fifo.pop_front();
				if (out_ch.score !== want) begin
					n_errors++;
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("score mismatch: expected 0x%08h, got 0x%08h",
							want, out_ch.score);
				end
			end
		end
	end

	task automatic send_posting(logic [TF_W-1:0] tf, logic [LEN_W-1:0] len);
		bit taken;
		if (idle_on && $urandom_range(99) < 20) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.term_frequency <= tf;
		in_ch.doc_len <= len;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end
		score_fifo.push_back(inl2_score(tf, len));
		n_requests++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (score_fifo.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_C_AVLEN) c_avlen_q = val[CAV_W-1:0];
		else query_idf_q = val[QIDF_W-1:0];
		n_cfg++;
	endtask

	function automatic logic [23:0] pick_field();
		case ($urandom_range(5))
			0: return '0;
			1: return 24'($urandom_range(16, 1));
			2: return 24'($urandom_range(4095));
			3: return 24'hffffff;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic test_reset_values();
		send_posting(24'd1, 24'd1);
		send_posting(24'd0, 24'd5);
		send_posting(24'd7, 24'd0);
		send_posting(24'hffffff, 24'hffffff);
		send_posting(24'hffffff, 24'd1);
	endtask

	task automatic test_field_extremes();
		write_reg(REG_C_AVLEN, 40'hff_ffff_ffff);
		write_reg(REG_QUERY_IDF, 40'hffff_ffff);
		send_posting(24'hffffff, 24'd1);
		send_posting(24'd1, 24'hffffff);
		send_posting(24'hffffff, 24'hffffff);
		send_posting(24'd1, 24'd1);
		send_posting(24'd0, 24'hffffff);
		send_posting(24'hffffff, 24'd0);
		send_posting(24'h555555, 24'haaaaaa);
		send_posting(24'haaaaaa, 24'h555555);
		write_reg(REG_C_AVLEN, 40'd0);
		send_posting(24'd3, 24'd3);
		send_posting(24'hffffff, 24'd1);
		send_posting(24'd9, 24'd0);
		write_reg(REG_QUERY_IDF, 40'd0);
		write_reg(REG_C_AVLEN, 40'd123456789);
		send_posting(24'd5, 24'd100);
		send_posting(24'd5, 24'd0);
	endtask

	task automatic test_random_postings();
		logic [CFG_W-1:0] v;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: v = 40'd1;
				1: v = 40'hff_ffff_ffff;
				2: v = 40'd65536 * 40'($urandom_range(1000, 1));
				default: v = {8'($urandom), 32'($urandom)};
			endcase
			write_reg(REG_C_AVLEN, v);
			case (ph)
				1: v = 40'hffff_ffff;
				2: v = 40'd0;
				3: v = 40'd1;
				default: v = 40'($urandom);
			endcase
			write_reg(REG_QUERY_IDF, v);
			for (int i = 0; i < 230; i++) begin
				idle_on = !(i >= 80 && i < 150);
				if (i == 190) begin
					in_ch.valid <= 1'b0;
					while (score_fifo.size() != 0) @(posedge clk);
				end
				send_posting(pick_field(), pick_field());
			end
			idle_on = 1'b1;
		end
	endtask

	initial begin
		for (int i = 0; i < 256; i++) log_frac_tab[i] = build_log_frac(i);
		c_avlen_q = CAV_W'(65536);
		query_idf_q = QIDF_W'(65536);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_field_extremes();
		test_random_postings();
		drain();
		n_errors += score_fifo.size();
		$display("Sent %0d postings, checked %0d scores across %0d register writes.",
			n_requests, n_scores, n_cfg);
		$display("Register settings included zero and full-scale values; %0d errors.",
			n_errors);
		if (n_errors == 0)
			$display("inl2_term_score_unit verification clean");
		else
			$display("inl2_term_score_unit verification failed");
		$finish;
	end

endmodule
